>>> src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is low
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, also checked during reset
`define CHK_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/gdet_pkg.sv
// shared constants, codes and types of the dual ema tracker
// no dependencies
package gdet_pkg;

    localparam int DAY_W    = 16;
    localparam int VAL_W    = 16;
    localparam int OFF_W    = 17;
    localparam int DELTA_W  = 17;
    localparam int RATE_W   = 20;
    localparam int AVG_W    = 24;
    localparam int STAT_W   = 2;
    localparam int GAIN_W   = 16;
    localparam int DIV_W    = 24;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 104;
    localparam int M_USER_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_GAP_DEF = 255;

    localparam logic [GAIN_W-1:0] SHORT_GAIN_RST = 16'd16384;
    localparam logic [GAIN_W-1:0] LONG_GAIN_RST  = 16'd4228;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_GAIN  = 2'd1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_NORMAL = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FIRST  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOPOS  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_CLAMP  = 2'd3;

    // which average a multiply request belongs to
    localparam logic TAG_FAST = 1'b0;
    localparam logic TAG_SLOW = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              tag;
        logic [AVG_W-1:0]  avg;
        logic [AVG_W-1:0]  value;
        logic [GAIN_W-1:0] gain;
    } mul_req_t;

    typedef struct packed {
        logic             valid;
        logic             tag;
        logic [AVG_W-1:0] result;
    } mul_rsp_t;

endpackage

>>> src/gap_filled_dual_ema_tracker_core.sv
// top level of the gap-filled dual ema tracker: sequencer, state and stream ports
// depends on gdet_pkg, gdet_div and gdet_ema_mul
//
// Takes dated samples (day number, value in 0.01 units) one transfer at a time and
// returns one result transfer per sample. The first sample after reset sets the day
// origin and seeds both averages (status first). A later sample reports its day
// offset, its change from the previous sample and the weekly rate change*7/gap
// truncated toward zero, then steps the fast and slow averages once per elapsed day
// on linearly interpolated values; averages carry 8 fraction bits. A gap of zero or
// less holds the averages and reports rate 0; a gap above MAX_GAP is clamped to
// MAX_GAP and flagged. A first sample or a non-positive gap goes from setup straight
// to the output; otherwise the serial divider is used twice (rate, then the per-day
// interpolation increment), followed by the per-day walk through the shared
// three-stage multiply unit, fast average then slow average. s_tready is high only
// while the sequencer is idle; a finished result sits in the output register, so the
// next sample may be taken while it waits. Gains are to be written by the user on
// the config port only while the block is idle; the block itself does not enforce
// this. Writes to indexes beyond the two gains are dropped.
module gap_filled_dual_ema_tracker_core #(
    parameter int MAX_GAP = gdet_pkg::MAX_GAP_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config write port
    input  logic                            cfg_wr_en,
    input  logic [gdet_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [gdet_pkg::GAIN_W-1:0]     cfg_wr_data,
    // sample stream in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gdet_pkg::S_DATA_W-1:0]   s_tdata,  // day_number[15:0], sample_value[31:16]
    // result stream out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gdet_pkg::M_DATA_W-1:0]   m_tdata,  // day_offset[16:0], delta[33:17],
                                                      // weekly_rate[53:34],
                                                      // fast_average[77:54],
                                                      // slow_average[101:78], zero pad
    output logic [gdet_pkg::M_USER_W-1:0]   m_tuser   // status[1:0]
);

    import gdet_pkg::*;

    // step counter and divisor width follow from the clamp limit
    localparam int GAP_W = $clog2(MAX_GAP + 1);
    localparam logic [DAY_W-1:0] MAX_GAP_V = DAY_W'(MAX_GAP);

    // sequencer codes
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SETUP     = 4'd1;
    localparam logic [3:0] S_DIV_RATE  = 4'd2;
    localparam logic [3:0] S_RATE_WAIT = 4'd3;
    localparam logic [3:0] S_DIV_STEP  = 4'd4;
    localparam logic [3:0] S_STEP_WAIT = 4'd5;
    localparam logic [3:0] S_INTERP    = 4'd6;
    localparam logic [3:0] S_VALUE     = 4'd7;
    localparam logic [3:0] S_ISSUE_F   = 4'd8;
    localparam logic [3:0] S_ISSUE_S   = 4'd9;
    localparam logic [3:0] S_EMA_WAIT  = 4'd10;
    localparam logic [3:0] S_OUT       = 4'd11;

    logic [3:0] state_reg, state_next;

    // config registers
    logic [GAIN_W-1:0] short_gain_reg, long_gain_reg;

    // tracker state
    logic             seen_first_reg;
    logic [DAY_W-1:0] origin_day_reg;
    logic [DAY_W-1:0] last_day_reg;
    logic [VAL_W-1:0] last_value_reg;
    logic [AVG_W-1:0] fast_reg;
    logic [AVG_W-1:0] slow_reg;

    // captured sample
    logic [DAY_W-1:0] day_reg;
    logic [VAL_W-1:0] val_reg;

    // per-sample working registers
    logic [OFF_W-1:0]   off_reg;
    logic [DELTA_W-1:0] delta_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [STAT_W-1:0]  status_reg;
    logic               neg_reg;
    logic [VAL_W-1:0]   abs_delta_reg;
    logic [AVG_W-1:0]   base_reg;
    logic [GAP_W-1:0]   g_reg;
    logic [GAP_W-1:0]   step_cnt_reg;
    logic [DIV_W-1:0]   qstep_reg;
    logic [GAP_W-1:0]   rstep_reg;
    logic [DIV_W-1:0]   qacc_reg;
    logic [GAP_W-1:0]   racc_reg;
    logic [AVG_W-1:0]   v_reg;

    // output register
    logic               m_valid_reg;
    logic [OFF_W-1:0]   m_off_reg;
    logic [DELTA_W-1:0] m_delta_reg;
    logic [RATE_W-1:0]  m_rate_reg;
    logic [AVG_W-1:0]   m_fast_reg;
    logic [AVG_W-1:0]   m_slow_reg;
    logic [STAT_W-1:0]  m_status_reg;

    // setup arithmetic on the captured sample
    logic signed [DAY_W:0] gap_s;
    logic [DELTA_W-1:0]    delta_s;
    logic [DELTA_W-1:0]    delta_neg;
    logic [OFF_W-1:0]      off_s;
    logic                  gap_pos;
    logic                  gap_clamp;

    assign gap_s     = $signed({1'b0, day_reg}) - $signed({1'b0, last_day_reg});
    assign delta_s   = {1'b0, val_reg} - {1'b0, last_value_reg};
    assign delta_neg = -delta_s;
    assign off_s     = {1'b0, day_reg} - {1'b0, origin_day_reg};
    assign gap_pos   = !gap_s[DAY_W] && (gap_s[DAY_W-1:0] != '0);
    assign gap_clamp = gap_pos && (gap_s[DAY_W-1:0] > MAX_GAP_V);

    // interpolation increment: running quotient and remainder of |delta|*256*i/g
    logic [GAP_W:0]   r_sum;
    logic             r_wrap;
    logic [GAP_W:0]   r_sub;
    logic [DIV_W-1:0] q_new;

    assign r_sum  = {1'b0, racc_reg} + {1'b0, rstep_reg};
    assign r_wrap = r_sum >= {1'b0, g_reg};
    assign r_sub  = r_sum - {1'b0, g_reg};
    assign q_new  = qacc_reg + qstep_reg + DIV_W'(r_wrap);

    // interpolated value, truncated toward zero by working on magnitudes
    logic signed [AVG_W+1:0] q_ext;
    logic signed [AVG_W+1:0] v_sum;

    assign q_ext = $signed({2'b00, qacc_reg});
    assign v_sum = $signed({2'b00, base_reg}) + (neg_reg ? -q_ext : q_ext);

    // rate from the divider quotient
    logic [RATE_W-1:0] rate_mag;
    assign rate_mag = div_quotient[RATE_W-1:0];

    // shared serial divider
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic             div_done;
    logic [DIV_W-1:0] div_quotient;
    logic [GAP_W-1:0] div_remainder;

    assign div_start    = (state_reg == S_DIV_RATE) || (state_reg == S_DIV_STEP);
    assign div_dividend = (state_reg == S_DIV_STEP) ? {abs_delta_reg, 8'h00}
                                                    : {8'h00, abs_delta_reg} * 24'd7;

    gdet_div #(
        .DVD_W (DIV_W),
        .DVS_W (GAP_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (g_reg),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // shared ema multiply unit, fast request then slow request each day
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    always_comb begin
        mul_req.valid = (state_reg == S_ISSUE_F) || (state_reg == S_ISSUE_S);
        mul_req.tag   = (state_reg == S_ISSUE_S) ? TAG_SLOW : TAG_FAST;
        mul_req.avg   = (state_reg == S_ISSUE_S) ? slow_reg : fast_reg;
        mul_req.gain  = (state_reg == S_ISSUE_S) ? long_gain_reg : short_gain_reg;
        mul_req.value = v_reg;
    end

    gdet_ema_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    // output slot is free when empty or being emptied this cycle
    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_SETUP;
            end
            S_SETUP: begin
                if (!seen_first_reg || !gap_pos) state_next = S_OUT;
                else state_next = S_DIV_RATE;
            end
            S_DIV_RATE:  state_next = S_RATE_WAIT;
            S_RATE_WAIT: begin
                if (div_done) state_next = S_DIV_STEP;
            end
            S_DIV_STEP:  state_next = S_STEP_WAIT;
            S_STEP_WAIT: begin
                if (div_done) state_next = S_INTERP;
            end
            S_INTERP:    state_next = S_VALUE;
            S_VALUE:     state_next = S_ISSUE_F;
            S_ISSUE_F:   state_next = S_ISSUE_S;
            S_ISSUE_S:   state_next = S_EMA_WAIT;
            S_EMA_WAIT: begin
                // the slow result is the last of the day
                if (mul_rsp.valid && (mul_rsp.tag == TAG_SLOW)) begin
                    if (step_cnt_reg == g_reg) state_next = S_OUT;
                    else state_next = S_INTERP;
                end
            end
            S_OUT: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            seen_first_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            short_gain_reg <= SHORT_GAIN_RST;
            long_gain_reg  <= LONG_GAIN_RST;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_SETUP) seen_first_reg <= 1'b1;
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            if ((state_reg == S_OUT) && out_free) m_valid_reg <= 1'b1;
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_SHORT_GAIN: short_gain_reg <= cfg_wr_data;
                    REG_LONG_GAIN:  long_gain_reg  <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    // tracker state: reset values matter only before the first sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_day_reg <= '0;
            last_day_reg   <= '0;
            last_value_reg <= '0;
            fast_reg       <= '0;
            slow_reg       <= '0;
        end else begin
            if (state_reg == S_SETUP) begin
                last_day_reg   <= day_reg;
                last_value_reg <= val_reg;
                if (!seen_first_reg) begin
                    origin_day_reg <= day_reg;
                    fast_reg       <= {val_reg, 8'h00};
                    slow_reg       <= {val_reg, 8'h00};
                end
            end
            if (mul_rsp.valid) begin
                if (mul_rsp.tag == TAG_SLOW) slow_reg <= mul_rsp.result;
                else fast_reg <= mul_rsp.result;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if ((state_reg == S_IDLE) && s_tvalid) begin
            day_reg <= s_tdata[DAY_W-1:0];
            val_reg <= s_tdata[DAY_W+VAL_W-1:DAY_W];
        end

        unique case (state_reg)
            S_SETUP: begin
                base_reg <= {last_value_reg, 8'h00};
                neg_reg  <= delta_s[DELTA_W-1];
                abs_delta_reg <= delta_s[DELTA_W-1] ? delta_neg[VAL_W-1:0]
                                                    : delta_s[VAL_W-1:0];
                g_reg <= gap_clamp ? GAP_W'(MAX_GAP) : gap_s[GAP_W-1:0];
                rate_reg <= '0;
                if (!seen_first_reg) begin
                    off_reg    <= '0;
                    delta_reg  <= '0;
                    status_reg <= STAT_FIRST;
                end else begin
                    off_reg   <= off_s;
                    delta_reg <= delta_s;
                    if (!gap_pos) status_reg <= STAT_NOPOS;
                    else if (gap_clamp) status_reg <= STAT_CLAMP;
                    else status_reg <= STAT_NORMAL;
                end
            end
            S_RATE_WAIT: begin
                if (div_done) rate_reg <= neg_reg ? -rate_mag : rate_mag;
            end
            S_STEP_WAIT: begin
                if (div_done) begin
                    qstep_reg    <= div_quotient;
                    rstep_reg    <= div_remainder;
                    qacc_reg     <= '0;
                    racc_reg     <= '0;
                    step_cnt_reg <= '0;
                end
            end
            S_INTERP: begin
                qacc_reg     <= q_new;
                racc_reg     <= r_wrap ? r_sub[GAP_W-1:0] : r_sum[GAP_W-1:0];
                step_cnt_reg <= step_cnt_reg + 1'b1;
            end
            S_VALUE: begin
                v_reg <= v_sum[AVG_W-1:0];
            end
            default: ;
        endcase

        if ((state_reg == S_OUT) && out_free) begin
            m_off_reg    <= off_reg;
            m_delta_reg  <= delta_reg;
            m_rate_reg   <= rate_reg;
            m_fast_reg   <= fast_reg;
            m_slow_reg   <= slow_reg;
            m_status_reg <= status_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_slow_reg, m_fast_reg, m_rate_reg, m_delta_reg, m_off_reg};
    assign m_tuser  = m_status_reg;

endmodule

>>> src/gdet_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
module gdet_div #(
    parameter int DVD_W = 24,
    parameter int DVS_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] trial_sub;
    logic           fits;

    assign trial     = {rem_reg, quo_reg[DVD_W-1]};
    assign fits      = trial >= {1'b0, dvs_reg};
    assign trial_sub = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> src/gdet_ema_mul.sv
// shared three-stage ema update: avg + ((value - avg) * gain + half) >>> 16
// depends on gdet_pkg
module gdet_ema_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  gdet_pkg::mul_req_t req,
    output gdet_pkg::mul_rsp_t rsp
);

    import gdet_pkg::*;

    localparam int DIFF_W = AVG_W + 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam int SUM_W  = AVG_W + 2;

    // stage 1: difference
    logic                     s1_valid_reg;
    logic                     s1_tag_reg;
    logic [AVG_W-1:0]         s1_avg_reg;
    logic signed [DIFF_W-1:0] s1_diff_reg;
    logic [GAIN_W-1:0]        s1_gain_reg;

    // stage 2: product
    logic                     s2_valid_reg;
    logic                     s2_tag_reg;
    logic [AVG_W-1:0]         s2_avg_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;

    // stage 3: rounded sum
    mul_rsp_t rsp_reg;

    logic signed [PROD_W-1:0] rounded;
    logic signed [PROD_W-1:0] shifted;
    logic signed [SUM_W-1:0]  sum;

    assign rounded = s2_prod_reg + PROD_W'(32768);
    assign shifted = rounded >>> 16;
    assign sum     = $signed({2'b00, s2_avg_reg}) + shifted[SUM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_reg.valid <= 1'b0;
        end else begin
            s1_valid_reg  <= req.valid;
            s2_valid_reg  <= s1_valid_reg;
            rsp_reg.valid <= s2_valid_reg;
        end
        s1_tag_reg  <= req.tag;
        s1_avg_reg  <= req.avg;
        s1_gain_reg <= req.gain;
        s1_diff_reg <= $signed({1'b0, req.value}) - $signed({1'b0, req.avg});

        s2_tag_reg  <= s1_tag_reg;
        s2_avg_reg  <= s1_avg_reg;
        s2_prod_reg <= s1_diff_reg * $signed({1'b0, s1_gain_reg});

        rsp_reg.tag    <= s2_tag_reg;
        rsp_reg.result <= sum[AVG_W-1:0];
    end

    assign rsp = rsp_reg;

endmodule

>>> src/gdet_checker.sv
// port-level checks of the dual ema tracker, bound to the top level
// depends on gdet_pkg and assert_macros.svh
`include "assert_macros.svh"

module gdet_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [gdet_pkg::S_DATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gdet_pkg::M_DATA_W-1:0] m_tdata,
    input logic [gdet_pkg::M_USER_W-1:0] m_tuser
);

    import gdet_pkg::*;

    logic s_xfer;
    logic first_zero;
    logic rate_zero;

    assign s_xfer     = s_tvalid && s_tready && (s_tdata == s_tdata);
    assign rate_zero  = (m_tdata[53:34] == '0);
    assign first_zero = (m_tdata[16:0] == '0) && (m_tdata[33:17] == '0) && rate_zero;

    // a stalled result holds
    `CHK_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // no result straight out of reset
    `CHK_ASSERT_NR(a_rst_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // ready is low in the cycle after a sample transfer
    `CHK_ASSERT(a_busy_after_xfer, aclk, aresetn, s_xfer |=> !s_tready, "ready right after sample transfer")

    // first sample reports zero offset, change and rate
    `CHK_ASSERT(a_first_zero, aclk, aresetn, m_tvalid && (m_tuser == STAT_FIRST) |-> first_zero, "first sample fields not zero")

    // non-positive gap reports zero rate
    `CHK_ASSERT(a_nopos_rate, aclk, aresetn, m_tvalid && (m_tuser == STAT_NOPOS) |-> rate_zero, "rate not zero on non-positive gap")

endmodule

bind gap_filled_dual_ema_tracker_core gdet_checker u_gdet_checker (.*);
